// ===== hdl/rational_alu_top_macros.svh =====
// Assertion helpers for the rational ALU.
`ifndef RATIONAL_ALU_TOP_MACROS_SVH
`define RATIONAL_ALU_TOP_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define RA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/ra_pkg.sv =====
package ra_pkg;

    localparam int DEFAULT_WORD_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2
    } order_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } out_t;

endpackage

// ===== hdl/rational_alu_top.sv =====
// rational_alu_top: exact add/sub/mul/div of two signed fractions, reduced by gcd.
// Sequence: result valid the cycle after the input transfer when a denominator is zero;
// otherwise operand a, operand b and the result are each reduced in turn (binary gcd,
// then division of numerator and denominator by it; a zero numerator gives 0/1),
// with the products formed on one multiplier and combined between b and the result.
// Throughput: one transfer at a time, next input taken the cycle after the result transfer.
// Reset: aresetn synchronous active low, returns to idle with no result pending.
`include "rational_alu_top_macros.svh"

module rational_alu_top
    import ra_pkg::*;
#(
    parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    // Effective result width is capped by the 32-bit output field.
    localparam int EffW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
    localparam logic [63:0] Lim = 64'(1) << (EffW - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RED_START, S_GCD, S_DIV_N, S_DIV_D, S_RED_END, S_MUL, S_COMBINE, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        STG_A, STG_B, STG_R
    } stage_t;

    state_t state_reg;
    stage_t stage_reg;
    logic   m_valid_reg;
    out_t   m_data_reg;

    // Held request.
    logic [1:0]  op_reg;
    logic [31:0] bn_raw_reg;
    logic [31:0] bd_raw_reg;

    // Value under reduction (sign in val_neg).
    logic [63:0] val_n_reg;
    logic [63:0] val_d_reg;
    logic        val_neg_reg;

    // Reduced operands.
    logic [31:0] a_n_reg, a_d_reg, b_n_reg, b_d_reg;
    logic        a_neg_reg, b_neg_reg;

    // Binary gcd working set.
    logic [63:0] gx_reg, gy_reg, g_reg;
    logic [5:0]  gk_reg;

    // Shift-subtract divider.
    logic [63:0] quo_reg, rem_reg;
    logic [5:0]  cnt_reg;

    // Products.
    logic [1:0]  mstep_reg;
    logic [63:0] lhs_reg, rhs_reg, pden_reg, pnum_reg;

    // Shared subtractor: gcd difference or divider trial subtract.
    logic [63:0] div_shift;
    logic [63:0] sub_a, sub_b;
    logic [64:0] diff;
    logic        gx_ge;
    logic [63:0] quo_step, rem_step;

    always_comb begin
        div_shift = {rem_reg[62:0], quo_reg[63]};
        gx_ge     = (gx_reg >= gy_reg);
        if (state_reg == S_GCD) begin
            sub_a = gx_ge ? gx_reg : gy_reg;
            sub_b = gx_ge ? gy_reg : gx_reg;
        end else begin
            sub_a = div_shift;
            sub_b = g_reg;
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        if (!diff[64]) begin
            rem_step = diff[63:0];
            quo_step = {quo_reg[62:0], 1'b1};
        end else begin
            rem_step = div_shift;
            quo_step = {quo_reg[62:0], 1'b0};
        end
    end

    // One 32x32 multiplier, operands chosen by step.
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;

    always_comb begin
        case (mstep_reg)
            2'd0: begin
                mul_x = a_n_reg;
                mul_y = b_d_reg;
            end
            2'd1: begin
                mul_x = b_n_reg;
                mul_y = a_d_reg;
            end
            2'd2: begin
                mul_x = a_d_reg;
                mul_y = (op_reg == OP_DIV) ? b_n_reg : b_d_reg;
            end
            default: begin
                mul_x = a_n_reg;
                mul_y = b_n_reg;
            end
        endcase
        prod = 64'(mul_x) * 64'(mul_y);
    end

    // Signed compare and add of the cross products.
    logic        rhs_eff_neg;
    logic        sum_neg;
    logic [63:0] sum_mag;
    logic [1:0]  cmp_order;
    logic        lhs_neg, rhs_neg;

    always_comb begin
        lhs_neg     = a_neg_reg && (lhs_reg != 64'd0);
        rhs_neg     = b_neg_reg && (rhs_reg != 64'd0);
        rhs_eff_neg = (op_reg == OP_SUB) ? (!rhs_neg && rhs_reg != 64'd0) : rhs_neg;
        if (lhs_neg == rhs_eff_neg) begin
            sum_neg = lhs_neg;
            sum_mag = lhs_reg + rhs_reg;
        end else if (lhs_reg >= rhs_reg) begin
            sum_neg = lhs_neg;
            sum_mag = lhs_reg - rhs_reg;
        end else begin
            sum_neg = rhs_eff_neg;
            sum_mag = rhs_reg - lhs_reg;
        end
        if (lhs_neg != rhs_neg) begin
            cmp_order = lhs_neg ? ORD_LESS : ORD_GREATER;
        end else if (lhs_reg == rhs_reg) begin
            cmp_order = ORD_EQUAL;
        end else if (lhs_neg) begin
            cmp_order = (lhs_reg > rhs_reg) ? ORD_LESS : ORD_GREATER;
        end else begin
            cmp_order = (lhs_reg < rhs_reg) ? ORD_LESS : ORD_GREATER;
        end
    end

    // Operand loading: magnitude and sign of a 32-bit two's complement pair.
    logic [31:0] an_mag, ad_mag, bn_mag, bd_mag;
    logic        ovf;

    assign an_mag = s_data.a_num[31] ? (~s_data.a_num + 32'd1) : s_data.a_num;
    assign ad_mag = s_data.a_den[31] ? (~s_data.a_den + 32'd1) : s_data.a_den;
    assign bn_mag = bn_raw_reg[31] ? (~bn_raw_reg + 32'd1) : bn_raw_reg;
    assign bd_mag = bd_raw_reg[31] ? (~bd_raw_reg + 32'd1) : bd_raw_reg;

    assign ovf = (val_d_reg > Lim - 64'd1) ||
                 (val_n_reg > (val_neg_reg ? Lim : Lim - 64'd1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            stage_reg   <= STG_A;
            m_valid_reg <= 1'b0;
            mstep_reg   <= 2'd0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_data.op;
                        bn_raw_reg <= s_data.b_num;
                        bd_raw_reg <= s_data.b_den;
                        if (s_data.a_den == 32'sd0 || s_data.b_den == 32'sd0) begin
                            m_data_reg.res_num <= '0;
                            m_data_reg.res_den <= '0;
                            m_data_reg.order   <= ORD_EQUAL;
                            m_data_reg.status  <= ST_ZERO_DEN;
                            m_valid_reg        <= 1'b1;
                            state_reg          <= S_OUT;
                        end else begin
                            val_n_reg   <= 64'(an_mag);
                            val_d_reg   <= 64'(ad_mag);
                            val_neg_reg <= (an_mag != 32'd0) &&
                                           (s_data.a_num[31] != s_data.a_den[31]);
                            stage_reg   <= STG_A;
                            state_reg   <= S_RED_START;
                        end
                    end
                end
                S_RED_START: begin
                    if (val_n_reg == 64'd0) begin
                        val_d_reg   <= 64'd1;
                        val_neg_reg <= 1'b0;
                        state_reg   <= S_RED_END;
                    end else begin
                        gx_reg    <= val_n_reg;
                        gy_reg    <= val_d_reg;
                        gk_reg    <= '0;
                        state_reg <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (gx_reg == 64'd0 || gy_reg == 64'd0) begin
                        g_reg     <= (gx_reg | gy_reg) << gk_reg;
                        quo_reg   <= val_n_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV_N;
                    end else if (!gx_reg[0] && !gy_reg[0]) begin
                        gx_reg <= gx_reg >> 1;
                        gy_reg <= gy_reg >> 1;
                        gk_reg <= gk_reg + 6'd1;
                    end else if (!gx_reg[0]) begin
                        gx_reg <= gx_reg >> 1;
                    end else if (!gy_reg[0]) begin
                        gy_reg <= gy_reg >> 1;
                    end else if (gx_ge) begin
                        gx_reg <= diff[63:0];
                    end else begin
                        gy_reg <= diff[63:0];
                    end
                end
                S_DIV_N: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == '1) begin
                        val_n_reg <= quo_step;
                        quo_reg   <= val_d_reg;
                        rem_reg   <= '0;
                        state_reg <= S_DIV_D;
                    end else begin
                        quo_reg <= quo_step;
                        rem_reg <= rem_step;
                    end
                end
                S_DIV_D: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    quo_reg <= quo_step;
                    rem_reg <= rem_step;
                    if (cnt_reg == '1) begin
                        val_d_reg <= quo_step;
                        state_reg <= S_RED_END;
                    end
                end
                S_RED_END: begin
                    case (stage_reg)
                        STG_A: begin
                            a_n_reg     <= val_n_reg[31:0];
                            a_d_reg     <= val_d_reg[31:0];
                            a_neg_reg   <= val_neg_reg;
                            val_n_reg   <= 64'(bn_mag);
                            val_d_reg   <= 64'(bd_mag);
                            val_neg_reg <= (bn_mag != 32'd0) && (bn_raw_reg[31] != bd_raw_reg[31]);
                            stage_reg   <= STG_B;
                            state_reg   <= S_RED_START;
                        end
                        STG_B: begin
                            b_n_reg   <= val_n_reg[31:0];
                            b_d_reg   <= val_d_reg[31:0];
                            b_neg_reg <= val_neg_reg;
                            mstep_reg <= 2'd0;
                            state_reg <= S_MUL;
                        end
                        default: begin
                            // Final check against the word width.
                            if (ovf) begin
                                m_data_reg.res_num <= '0;
                                m_data_reg.res_den <= '0;
                                m_data_reg.status  <= ST_OVERFLOW;
                            end else begin
                                m_data_reg.res_num <= val_neg_reg ?
                                    (~val_n_reg[31:0] + 32'd1) : val_n_reg[31:0];
                                m_data_reg.res_den <= val_d_reg[30:0];
                                m_data_reg.status  <= ST_OK;
                            end
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end
                    endcase
                end
                S_MUL: begin
                    mstep_reg <= mstep_reg + 2'd1;
                    case (mstep_reg)
                        2'd0: lhs_reg <= prod;
                        2'd1: rhs_reg <= prod;
                        2'd2: begin
                            pden_reg <= prod;
                            if (op_reg != OP_MUL) begin
                                state_reg <= S_COMBINE;
                            end
                        end
                        default: begin
                            pnum_reg  <= prod;
                            state_reg <= S_COMBINE;
                        end
                    endcase
                end
                S_COMBINE: begin
                    m_data_reg.order <= cmp_order;
                    val_d_reg        <= pden_reg;
                    stage_reg        <= STG_R;
                    state_reg        <= S_RED_START;
                    case (op_reg)
                        OP_ADD, OP_SUB: begin
                            val_n_reg   <= sum_mag;
                            val_neg_reg <= sum_neg && (sum_mag != 64'd0);
                        end
                        OP_MUL: begin
                            val_n_reg   <= pnum_reg;
                            val_neg_reg <= (a_neg_reg != b_neg_reg) && (pnum_reg != 64'd0);
                        end
                        default: begin
                            val_n_reg   <= lhs_reg;
                            val_neg_reg <= (a_neg_reg != b_neg_reg) && (lhs_reg != 64'd0);
                            if (b_n_reg == 32'd0) begin
                                // Drop to a division-by-zero result.
                                m_data_reg.res_num <= '0;
                                m_data_reg.res_den <= '0;
                                m_data_reg.status  <= ST_DIV_ZERO;
                                m_valid_reg        <= 1'b1;
                                state_reg          <= S_OUT;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    // Hold the result until the transfer completes.
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RA_ASSERT(a_no_overlap, !(s_ready && m_valid), "input taken while a result is pending")
    `RA_ASSERT(a_ok_den, (m_valid && m_data.status == ST_OK) |-> (m_data.res_den != 31'd0), "ok result with zero denominator")
    `RA_ASSERT(a_err_zero, (m_valid && m_data.status != ST_OK) |-> (m_data.res_num == 32'sd0 && m_data.res_den == 31'd0), "error result not zeroed")
    `RA_ASSERT(a_zden_order, (m_valid && m_data.status == ST_ZERO_DEN) |-> (m_data.order == ORD_EQUAL), "zero denominator must report equal")

endmodule

// ===== dv/tb_rational_alu_top.sv =====
`timescale 1ns / 1ps

module tb_rational_alu_top;
    import ra_pkg::*;

    localparam int  N_RANDOM    = 1950;
    localparam int  CYCLE_LIMIT = 10000000;
    localparam int  DRAIN_WAIT  = 1000;
    localparam int  RING_DEPTH  = 16;
    localparam int  MAX_ROWS    = 16;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    always #4 aclk = ~aclk;

    rational_alu_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Directed rows: a fixed expectation where obvious, otherwise predicted.
    typedef struct {
        in_t  item;
        bit   fixed;
        out_t result;
    } row_t;

    // Expected results, oldest first.
    out_t exp_ring[RING_DEPTH];
    int   exp_wr = 0;
    int   exp_rd = 0;
    row_t rows[MAX_ROWS];
    int   n_rows = 0;
    int   mismatches = 0;
    int   cycles = 0;
    bit   stim_done = 1'b0;

    // Signed magnitude helpers at 128 bits: every intermediate fits exactly.
    function automatic logic signed [127:0] gcd_mag(logic signed [127:0] x,
                                                    logic signed [127:0] y);
        logic signed [127:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic out_t predict_fraction(in_t it);
        out_t r;
        logic signed [127:0] an, ad, bn, bd, g, lhs, rhs, rn, rd, lim;
        r = '0;
        r.order = ORD_EQUAL;
        if (it.a_den == 0 || it.b_den == 0) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        an = it.a_num; ad = it.a_den; bn = it.b_num; bd = it.b_den;
        // move sign into the numerator, then reduce
        if (ad < 0) begin an = -an; ad = -ad; end
        if (bd < 0) begin bn = -bn; bd = -bd; end
        if (an == 0) ad = 1;
        else begin g = gcd_mag(an < 0 ? -an : an, ad); an = an / g; ad = ad / g; end
        if (bn == 0) bd = 1;
        else begin g = gcd_mag(bn < 0 ? -bn : bn, bd); bn = bn / g; bd = bd / g; end
        lhs = an * bd;
        rhs = bn * ad;
        r.order = (lhs < rhs) ? ORD_LESS : (lhs == rhs) ? ORD_EQUAL : ORD_GREATER;
        case (op_t'(it.op))
            OP_ADD: begin rn = lhs + rhs; rd = ad * bd; end
            OP_SUB: begin rn = lhs - rhs; rd = ad * bd; end
            OP_MUL: begin rn = an * bn; rd = ad * bd; end
            default: begin
                if (bn == 0) begin
                    r.status = ST_DIV_ZERO;
                    return r;
                end
                rn = an * bd;
                rd = ad * (bn < 0 ? -bn : bn);
                if (bn < 0) rn = -rn;
            end
        endcase
        if (rn == 0) rd = 1;
        else begin g = gcd_mag(rn < 0 ? -rn : rn, rd); rn = rn / g; rd = rd / g; end
        lim = 128'sd1 <<< 31;
        if (rd > lim - 1 || rn > lim - 1 || rn < -lim) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.res_num = rn[31:0];
        r.res_den = rd[30:0];
        r.status  = ST_OK;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Draw a field value biased toward extremes and small magnitudes.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            4, 5: return $urandom_range(0, 40) - 20;
            6: return $urandom_range(0, 2000) * (($urandom_range(0, 1)) ? -1 : 1);
            default: return $urandom();
        endcase
    endfunction

    task automatic add_row(row_t r);
        rows[n_rows] = r;
        n_rows++;
    endtask

    task automatic send_item(in_t it, bit fixed, out_t want);
        int g;
        g = gap_len();
        // drop valid only when an idle gap follows
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        exp_ring[exp_wr % RING_DEPTH] = fixed ? want : predict_fraction(it);
        exp_wr++;
        s_valid <= 1'b1;
        s_data  <= it;
        // hold the transfer until accepted
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stimulus
    initial begin
        row_t rw;
        in_t  it;
        out_t zd, dz;
        zd = '0; zd.order = ORD_EQUAL; zd.status = ST_ZERO_DEN;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero denominators: fixed error result
        rw.fixed = 1; rw.result = zd;
        rw.item = '{OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1}; add_row(rw);
        rw.item = '{OP_DIV, 32'sd5, 32'sd3, 32'sd7, 32'sd0}; add_row(rw);
        rw.item = '{OP_MUL, 32'sd0, 32'sd0, 32'sd0, 32'sd0}; add_row(rw);
        // division by zero: a = 1/2 greater than b = 0
        dz = '0; dz.order = ORD_GREATER; dz.status = ST_DIV_ZERO;
        rw.result = dz;
        rw.item = '{OP_DIV, 32'sd1, 32'sd2, 32'sd0, -32'sd5}; add_row(rw);
        // zero result is 0/1
        rw.result = '{32'sd0, 31'd1, ORD_EQUAL, ST_OK};
        rw.item = '{OP_SUB, 32'sd3, 32'sd4, -32'sd6, -32'sd8}; add_row(rw);
        // -2^31 / -1 overflows as a result on multiply by 1
        rw.result = '{32'sd0, 31'd0, ORD_GREATER, ST_OVERFLOW};
        rw.item = '{OP_MUL, 32'h8000_0000, -32'sd1, 32'sd1, 32'sd1}; add_row(rw);
        rw.fixed = 0;
        rw.item = '{OP_ADD, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1}; add_row(rw);
        rw.item = '{OP_SUB, 32'h8000_0000, 32'sd1, 32'sd1, 32'sd1}; add_row(rw);
        rw.item = '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'sd3, -32'sd9}; add_row(rw);
        rw.item = '{OP_DIV, 32'sd1, 32'h7fff_ffff, 32'sd1, 32'h8000_0000}; add_row(rw);
        rw.item = '{OP_DIV, -32'sd6, 32'sd4, 32'sd9, -32'sd3}; add_row(rw);
        rw.item = '{OP_ADD, 32'sd1, 32'sd3, 32'sd1, 32'sd6}; add_row(rw);
        rw.item = '{OP_MUL, 32'h8000_0000, 32'sd1, 32'h8000_0000, 32'sd1}; add_row(rw);
        rw.item = '{OP_DIV, 32'h7fff_ffff, 32'sd2, 32'h7fff_ffff, 32'sd3}; add_row(rw);
        rw.item = '{OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'sd2, 32'h7fff_fffe};
        add_row(rw);
        for (int i = 0; i < n_rows; i++) send_item(rows[i].item, rows[i].fixed, rows[i].result);

        for (int n = 0; n < N_RANDOM; n++) begin
            it.op    = 2'($urandom_range(0, 3));
            it.a_num = rand_word();
            it.b_num = rand_word();
            it.a_den = rand_word();
            it.b_den = rand_word();
            // keep zero denominators rare
            if (it.a_den == 0 && $urandom_range(0, 3) != 0) it.a_den = 1;
            if (it.b_den == 0 && $urandom_range(0, 3) != 0) it.b_den = -1;
            send_item(it, 1'b0, '0);
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random stalls, compare each transfer with the oldest expectation
    initial begin
        out_t want;
        int   g;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (exp_wr == exp_rd) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", m_data);
                end else begin
                    want = exp_ring[exp_rd % RING_DEPTH];
                    exp_rd++;
                    if (m_data.res_num !== want.res_num || m_data.res_den !== want.res_den ||
                        m_data.order !== want.order || m_data.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, m_data);
                    end
                end
            end
            // advance the stall pattern, including runs with ready held high
            g = gap_len();
            m_ready <= (g == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // End of run and timeout
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
            if (stim_done && exp_wr == exp_rd) begin
                repeat (DRAIN_WAIT) @(posedge aclk);
                if (mismatches == 0 && exp_wr == exp_rd)
                    $display("ALL CHECKS PASSED");
                else
                    $display("CHECKS FAILED");
                $finish;
            end
        end
    end
endmodule
